/* design/pwsr_pkg.sv */
// Package for the pulse-width symbol receiver: shared constants, the
// symbol range table and the result item type.
// Depends on nothing; pwsr_front, pwsr_back and the top level use it.
`timescale 1ns / 1ps

package pwsr_pkg;

	// Default width of the free-running edge timer.
	localparam int TIME_BITS_DEF = 16;

	// Width of the timestamp and length fields on the ports.
	localparam int FIELD_BITS = 16;

	// Number of table entries and width of one symbol.
	localparam int SYM_COUNT = 16;
	localparam int SYM_BITS  = 4;
	localparam int BYTE_BITS = 8;

	// Depth of the queue between front and back, and of the result queue.
	localparam int PAIR_DEPTH_DEF   = 2;
	localparam int RESULT_DEPTH_DEF = 2;

	// One inclusive burst range and one inclusive gap range.
	typedef struct packed {
		logic [FIELD_BITS-1:0] burst_lo;
		logic [FIELD_BITS-1:0] burst_hi;
		logic [FIELD_BITS-1:0] gap_lo;
		logic [FIELD_BITS-1:0] gap_hi;
	} range_t;

	// The entry index is the symbol value; the lowest matching entry wins.
	localparam range_t RANGE_TABLE [SYM_COUNT] = '{
		'{16'd87,  16'd174, 16'd141, 16'd207},
		'{16'd87,  16'd174, 16'd210, 16'd276},
		'{16'd87,  16'd174, 16'd280, 16'd345},
		'{16'd87,  16'd174, 16'd349, 16'd415},
		'{16'd87,  16'd174, 16'd418, 16'd484},
		'{16'd87,  16'd174, 16'd488, 16'd554},
		'{16'd191, 16'd278, 16'd141, 16'd207},
		'{16'd191, 16'd278, 16'd210, 16'd276},
		'{16'd191, 16'd278, 16'd280, 16'd345},
		'{16'd191, 16'd278, 16'd349, 16'd415},
		'{16'd191, 16'd278, 16'd418, 16'd484},
		'{16'd295, 16'd382, 16'd141, 16'd207},
		'{16'd295, 16'd382, 16'd210, 16'd276},
		'{16'd295, 16'd382, 16'd280, 16'd345},
		'{16'd399, 16'd486, 16'd141, 16'd207},
		'{16'd399, 16'd486, 16'd210, 16'd276}
	};

	// One result item as it sits in the result queue.
	typedef struct packed {
		logic                  symbol_valid;
		logic [SYM_BITS-1:0]   symbol_value;
		logic [FIELD_BITS-1:0] burst_length;
		logic [FIELD_BITS-1:0] gap_length;
		logic                  byte_ready;
		logic [BYTE_BITS-1:0]  byte_value;
	} result_t;

endpackage

/* design/pwsr_fifo.sv */
// Small first-in first-out queue built from registers.
// Used between the front and back parts and in front of the result ports.
// Depends on nothing.
`timescale 1ns / 1ps

module pwsr_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  logic [WIDTH-1:0] wr_data,
	output logic             full,
	input  logic             rd_en,
	output logic [WIDTH-1:0] rd_data,
	output logic             empty
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wr_ptr_q;
	logic [AW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             do_wr;
	logic             do_rd;

	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Storage needs no reset; an entry is read only after it was written.
	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	// A write into a queue that is not read must leave it holding an item.
	a_write_fills: assert property (@(posedge clk) disable iff (!arst_n)
		do_wr && !do_rd |=> !empty)
		else $error("queue empty after an unmatched write");

endmodule

/* design/pwsr_front.sv */
// Front part of the receiver: accepts edge timestamps, measures burst
// and gap durations and queues each completed burst/gap pair.
// Depends on pwsr_pkg.
`timescale 1ns / 1ps

module pwsr_front #(
	parameter int TIME_BITS = pwsr_pkg::TIME_BITS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic [pwsr_pkg::FIELD_BITS-1:0] edge_time,
	input  logic                       push,
	input  logic                       stall,
	output logic                       pair_wr_en,
	output logic [2*TIME_BITS-1:0]     pair_data
);

	localparam int EXT_BITS = (TIME_BITS > pwsr_pkg::FIELD_BITS) ?
		TIME_BITS : pwsr_pkg::FIELD_BITS;

	// Edge phase codes; the spare code behaves like the gap phase.
	localparam logic [1:0] PH_IDLE  = 2'd0;
	localparam logic [1:0] PH_BURST = 2'd1;
	localparam logic [1:0] PH_GAP   = 2'd2;
	localparam logic [1:0] PH_SPARE = 2'd3;

	logic [1:0]           phase_q;
	logic [TIME_BITS-1:0] prev_q;
	logic [TIME_BITS-1:0] held_burst_q;
	logic [EXT_BITS-1:0]  edge_ext;
	logic [TIME_BITS-1:0] now;
	logic [TIME_BITS-1:0] span;
	logic                 accept;

	// Timestamp at timer width and the wrapping duration since the last edge.
	assign edge_ext = EXT_BITS'(edge_time);
	assign now      = edge_ext[TIME_BITS-1:0];
	assign span     = now - prev_q;
	assign accept   = push && !stall;

	// An edge that closes the gap hands the pair to the back part.
	assign pair_wr_en = accept && (phase_q == PH_GAP || phase_q == PH_SPARE);
	assign pair_data  = {held_burst_q, span};

	// Edge phase sequencing.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
		end else if (accept) begin
			unique case (phase_q)
				PH_IDLE:  phase_q <= PH_BURST;
				PH_BURST: phase_q <= PH_GAP;
				default:  phase_q <= PH_BURST;
			endcase
		end
	end

	// Last timestamp and the held burst length.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q       <= '0;
			held_burst_q <= '0;
		end else if (accept) begin
			prev_q <= now;
			if (phase_q == PH_BURST) begin
				held_burst_q <= span;
			end
		end
	end

	// The first edge after reset only opens a burst.
	a_first_edge: assert property (@(posedge clk) disable iff (!arst_n)
		accept && phase_q == PH_IDLE |=> phase_q == PH_BURST && !$past(pair_wr_en))
		else $error("first edge did not open a burst");

	// A queued pair always leaves the next burst running.
	a_pair_restarts: assert property (@(posedge clk) disable iff (!arst_n)
		pair_wr_en |=> phase_q == PH_BURST)
		else $error("gap edge did not start the next burst");

endmodule

/* design/pwsr_back.sv */
// Back part of the receiver: classifies each queued burst/gap pair
// against the range table and pairs valid symbols into bytes.
// Depends on pwsr_pkg.
`timescale 1ns / 1ps

module pwsr_back #(
	parameter int TIME_BITS = pwsr_pkg::TIME_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   pair_empty,
	input  logic [2*TIME_BITS-1:0] pair_data,
	output logic                   pair_rd_en,
	input  logic                   res_full,
	output logic                   res_push,
	output pwsr_pkg::result_t      res_data
);

	localparam int EXT_BITS = (TIME_BITS > pwsr_pkg::FIELD_BITS) ?
		TIME_BITS : pwsr_pkg::FIELD_BITS;

	logic [EXT_BITS-1:0]            burst_ext;
	logic [EXT_BITS-1:0]            gap_ext;
	logic                           hit;
	logic [pwsr_pkg::SYM_BITS-1:0]  sym;
	logic                           step;
	logic                           awaiting_q;
	logic [pwsr_pkg::SYM_BITS-1:0]  high_q;

	assign burst_ext  = EXT_BITS'(pair_data[2*TIME_BITS-1:TIME_BITS]);
	assign gap_ext    = EXT_BITS'(pair_data[TIME_BITS-1:0]);
	assign step       = !pair_empty && !res_full;
	assign pair_rd_en = step;
	assign res_push   = step;

	// Parallel range compares; scanning downward lets the lowest entry win.
	always_comb begin
		hit = 1'b0;
		sym = '0;
		for (int k = pwsr_pkg::SYM_COUNT - 1; k >= 0; k--) begin
			if (burst_ext >= EXT_BITS'(pwsr_pkg::RANGE_TABLE[k].burst_lo) &&
			    burst_ext <= EXT_BITS'(pwsr_pkg::RANGE_TABLE[k].burst_hi) &&
			    gap_ext   >= EXT_BITS'(pwsr_pkg::RANGE_TABLE[k].gap_lo) &&
			    gap_ext   <= EXT_BITS'(pwsr_pkg::RANGE_TABLE[k].gap_hi)) begin
				hit = 1'b1;
				sym = pwsr_pkg::SYM_BITS'(k);
			end
		end
	end

	// Result item for this pair.
	always_comb begin
		res_data.symbol_valid = hit;
		res_data.symbol_value = hit ? sym : '0;
		res_data.burst_length = burst_ext[pwsr_pkg::FIELD_BITS-1:0];
		res_data.gap_length   = gap_ext[pwsr_pkg::FIELD_BITS-1:0];
		res_data.byte_ready   = hit && awaiting_q;
		res_data.byte_value   = (hit && awaiting_q) ? {high_q, sym} : '0;
	end

	// Nibble pairing; an unmatched pair leaves it untouched.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			awaiting_q <= 1'b0;
			high_q     <= '0;
		end else if (step && hit) begin
			if (awaiting_q) begin
				awaiting_q <= 1'b0;
				high_q     <= '0;
			end else begin
				awaiting_q <= 1'b1;
				high_q     <= sym;
			end
		end
	end

	// An unmatched pair must not disturb the nibble pairing.
	a_invalid_holds: assert property (@(posedge clk) disable iff (!arst_n)
		res_push && !res_data.symbol_valid |=> $stable(awaiting_q) && $stable(high_q))
		else $error("unmatched pair changed the nibble pairing");

	// A completed byte returns the pairing to the high nibble.
	a_byte_resets: assert property (@(posedge clk) disable iff (!arst_n)
		res_push && res_data.byte_ready |=> !awaiting_q && high_q == '0)
		else $error("pairing not cleared after a byte");

endmodule

/* design/pulse_width_symbol_receiver_unit.sv */
// Top level of the pulse-width symbol receiver: front part, pair queue,
// back part and result queue.
// Depends on pwsr_pkg, pwsr_fifo, pwsr_front and pwsr_back.
//
//   Channel   Handshake           Fields
//   -------   -----------------   ------------------------------------------
//   edges     push / full         edge_time
//   results   empty / pop         symbol_valid, symbol_value, burst_length,
//                                 gap_length, byte_ready, byte_value
//
// One edge item is accepted per cycle while full is low; every other edge from the third on
// (each gap-closing edge) yields one result item.
// A result reaches the result ports through both queues: the pair enters the pair
// queue at the edge that accepts it and passes the range compare into the result
// queue once that queue has room; only then can it be popped.
// full rises only when the pair queue holds PAIR_DEPTH pairs that the stalled
// back part could not move; edges that close no pair are still held off then.
// Reset is asynchronous and returns the edge phase and nibble pairing to
// their start and empties both queues.
`timescale 1ns / 1ps

module pulse_width_symbol_receiver_unit #(
	parameter int TIME_BITS    = pwsr_pkg::TIME_BITS_DEF,
	parameter int PAIR_DEPTH   = pwsr_pkg::PAIR_DEPTH_DEF,
	parameter int RESULT_DEPTH = pwsr_pkg::RESULT_DEPTH_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic [pwsr_pkg::FIELD_BITS-1:0]  edge_time,
	input  logic                             push,
	output logic                             full,
	output logic                             empty,
	input  logic                             pop,
	output logic                             symbol_valid,
	output logic [pwsr_pkg::SYM_BITS-1:0]    symbol_value,
	output logic [pwsr_pkg::FIELD_BITS-1:0]  burst_length,
	output logic [pwsr_pkg::FIELD_BITS-1:0]  gap_length,
	output logic                             byte_ready,
	output logic [pwsr_pkg::BYTE_BITS-1:0]   byte_value
);

	localparam int RES_BITS = $bits(pwsr_pkg::result_t);

	logic                   pair_wr_en;
	logic [2*TIME_BITS-1:0] pair_wr_data;
	logic                   pair_full;
	logic                   pair_rd_en;
	logic [2*TIME_BITS-1:0] pair_rd_data;
	logic                   pair_empty;
	logic                   res_push;
	logic                   res_full;
	pwsr_pkg::result_t      res_in;
	pwsr_pkg::result_t      res_out;
	logic [RES_BITS-1:0]    res_out_bits;

	assign full = pair_full;

	// Front part: edge phase and duration measurement.
	pwsr_front #(
		.TIME_BITS(TIME_BITS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.edge_time (edge_time),
		.push      (push),
		.stall     (pair_full),
		.pair_wr_en(pair_wr_en),
		.pair_data (pair_wr_data)
	);

	// Queue of burst/gap pairs between the two parts.
	pwsr_fifo #(
		.WIDTH(2 * TIME_BITS),
		.DEPTH(PAIR_DEPTH)
	) u_pair_q (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (pair_wr_en),
		.wr_data(pair_wr_data),
		.full   (pair_full),
		.rd_en  (pair_rd_en),
		.rd_data(pair_rd_data),
		.empty  (pair_empty)
	);

	// Back part: classification and byte assembly.
	pwsr_back #(
		.TIME_BITS(TIME_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pair_empty(pair_empty),
		.pair_data (pair_rd_data),
		.pair_rd_en(pair_rd_en),
		.res_full  (res_full),
		.res_push  (res_push),
		.res_data  (res_in)
	);

	// Result queue that drives the result ports.
	pwsr_fifo #(
		.WIDTH(RES_BITS),
		.DEPTH(RESULT_DEPTH)
	) u_result_q (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (res_push),
		.wr_data(res_in),
		.full   (res_full),
		.rd_en  (pop),
		.rd_data(res_out_bits),
		.empty  (empty)
	);

	assign res_out      = pwsr_pkg::result_t'(res_out_bits);
	assign symbol_valid = res_out.symbol_valid;
	assign symbol_value = res_out.symbol_value;
	assign burst_length = res_out.burst_length;
	assign gap_length   = res_out.gap_length;
	assign byte_ready   = res_out.byte_ready;
	assign byte_value   = res_out.byte_value;

endmodule

/* verif/tb_top.sv */
// Testbench for pulse_width_symbol_receiver_unit: decodes edge timestamps in step with the block
// and compares every symbol result field by field, under varying push and pop idling.
// Depends on pwsr_pkg and the design files under design/.
`timescale 1ns / 1ps

module tb_top;

	typedef logic [pwsr_pkg::FIELD_BITS-1:0] tick_t;
	typedef enum logic [1:0] {STAGE_IDLE, STAGE_BURST, STAGE_GAP} pulse_stage_t;
	typedef enum int {MIX_STEADY, MIX_SENDER_IDLE, MIX_RECEIVER_STALL, MIX_BOTH} idle_mix_t;

	// One timestamp waiting to be pushed; after_drain holds it back until all results are out.
	typedef struct {
		tick_t stamp;
		bit    after_drain;
	} edge_item_t;

	localparam int RESET_CYCLES  = 11;
	localparam int MIX_SPAN      = 96;
	localparam int RANDOM_PAIRS  = 515;
	localparam int HEAVY_PCT     = 56;
	localparam int LIGHT_PCT     = 12;
	localparam int TAIL_CYCLES   = 8;
	localparam int MAX_REPORTS   = 40;
	localparam int RUN_LIMIT_NS  = 1000000;

	logic                                 clk = 1'b0;
	logic                                 arst_n = 1'b0;
	logic                                 push = 1'b0;
	logic                                 pop = 1'b0;
	tick_t                                edge_time = '0;
	logic                                 full;
	logic                                 empty;
	logic                                 symbol_valid;
	logic [pwsr_pkg::SYM_BITS-1:0]        symbol_value;
	tick_t                                burst_length;
	tick_t                                gap_length;
	logic                                 byte_ready;
	logic [pwsr_pkg::BYTE_BITS-1:0]       byte_value;

	// Stimulus and decoded results in flight.
	edge_item_t        edge_stamps[$];
	pwsr_pkg::result_t symbols_in_flight[$];
	tick_t             gen_stamp = '0;

	// Decoder state kept alongside the block.
	tick_t                          last_stamp = '0;
	pulse_stage_t                   stage = STAGE_IDLE;
	tick_t                          burst_held = '0;
	bit                             low_nibble_due = 1'b0;
	logic [pwsr_pkg::SYM_BITS-1:0]  upper_nibble = '0;

	int edges_accepted = 0;
	int edges_retired = 0;
	int results_checked = 0;
	int symbols_matched = 0;
	int pairs_unmatched = 0;
	int bytes_built = 0;
	int mismatches = 0;

	pulse_width_symbol_receiver_unit i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.edge_time    (edge_time),
		.push         (push),
		.full         (full),
		.empty        (empty),
		.pop          (pop),
		.symbol_valid (symbol_valid),
		.symbol_value (symbol_value),
		.burst_length (burst_length),
		.gap_length   (gap_length),
		.byte_ready   (byte_ready),
		.byte_value   (byte_value)
	);

	always #1 clk = ~clk;

	// The first table entry whose burst and gap ranges both hold wins; -1 if none does.
	function automatic int match_symbol(input tick_t burst, input tick_t gap);
		for (int k = 0; k < pwsr_pkg::SYM_COUNT; k++) begin
			if (burst >= pwsr_pkg::RANGE_TABLE[k].burst_lo &&
				burst <= pwsr_pkg::RANGE_TABLE[k].burst_hi &&
				gap >= pwsr_pkg::RANGE_TABLE[k].gap_lo &&
				gap <= pwsr_pkg::RANGE_TABLE[k].gap_hi) begin
				return k;
			end
		end
		return -1;
	endfunction

	// Advance the decoder by one edge. The timer is as wide as the field, so the
	// 16-bit subtraction already wraps the way the timer does.
	task automatic decode_edge(input tick_t now);
		tick_t             span;
		pwsr_pkg::result_t item;
		int                sym;
		span = now - last_stamp;
		last_stamp = now;
		case (stage)
			STAGE_IDLE: begin
				stage = STAGE_BURST;
			end
			STAGE_BURST: begin
				burst_held = span;
				stage = STAGE_GAP;
			end
			default: begin
				// The gap-closing edge also opens the next burst.
				stage = STAGE_BURST;
				sym = match_symbol(burst_held, span);
				item = '0;
				item.burst_length = burst_held;
				item.gap_length = span;
				if (sym >= 0) begin
					item.symbol_valid = 1'b1;
					item.symbol_value = sym[pwsr_pkg::SYM_BITS-1:0];
					if (low_nibble_due) begin
						item.byte_ready = 1'b1;
						item.byte_value = {upper_nibble, sym[pwsr_pkg::SYM_BITS-1:0]};
						upper_nibble = '0;
						low_nibble_due = 1'b0;
					end else begin
						upper_nibble = sym[pwsr_pkg::SYM_BITS-1:0];
						low_nibble_due = 1'b1;
					end
				end
				symbols_in_flight.push_back(item);
			end
		endcase
	endtask

	// Print one line per mismatch; past the cap they are only counted.
	task automatic report_mismatch(input string text);
		mismatches++;
		if (mismatches <= MAX_REPORTS) begin
			$display("MISMATCH at %0t: %s", $realtime, text);
		end
	endtask

	task automatic compare_field(input string name, input tick_t got, input tick_t want);
		if (got !== want) begin
			report_mismatch($sformatf("result %0d %s: got 0x%0h, want 0x%0h",
				results_checked, name, got, want));
		end
	endtask

	task automatic queue_edge(input tick_t span, input bit after_drain);
		gen_stamp = gen_stamp + span;
		edge_stamps.push_back('{gen_stamp, after_drain});
	endtask

	// A burst-closing edge followed by a gap-closing edge.
	task automatic queue_pair(input tick_t burst, input tick_t gap, input bit after_drain);
		queue_edge(burst, after_drain);
		queue_edge(gap, 1'b0);
	endtask

	function automatic tick_t near_bound(input tick_t lo, input tick_t hi);
		case ($urandom_range(3))
			0: return lo - 1'b1;
			1: return lo;
			2: return hi;
			default: return hi + 1'b1;
		endcase
	endfunction

	// Mostly well-formed symbols, some range edges, some noise.
	task automatic queue_random_pair(input bit after_drain);
		pwsr_pkg::range_t entry;
		int               pick;
		tick_t            burst;
		tick_t            gap;
		entry = pwsr_pkg::RANGE_TABLE[$urandom_range(pwsr_pkg::SYM_COUNT - 1)];
		pick = $urandom_range(99);
		if (pick < 70) begin
			burst = tick_t'($urandom_range(entry.burst_hi, entry.burst_lo));
			gap = tick_t'($urandom_range(entry.gap_hi, entry.gap_lo));
		end else if (pick < 85) begin
			burst = near_bound(entry.burst_lo, entry.burst_hi);
			gap = near_bound(entry.gap_lo, entry.gap_hi);
		end else if (pick < 93) begin
			burst = tick_t'($urandom_range(600));
			gap = tick_t'($urandom_range(600));
		end else begin
			burst = tick_t'($urandom);
			gap = tick_t'($urandom);
		end
		queue_pair(burst, gap, after_drain);
	endtask

	// Drive at the falling edge; retire items that the rising edge accepted.
	always @(negedge clk) begin : drive_ports
		idle_mix_t mix;
		int        send_idle;
		int        recv_stall;
		mix = idle_mix_t'((edges_accepted / MIX_SPAN) % 4);
		send_idle = (mix == MIX_SENDER_IDLE) ? HEAVY_PCT : (mix == MIX_BOTH) ? LIGHT_PCT : 0;
		recv_stall = (mix == MIX_RECEIVER_STALL) ? HEAVY_PCT : (mix == MIX_BOTH) ? LIGHT_PCT : 0;
		if (edges_retired != edges_accepted) begin
			void'(edge_stamps.pop_front());
			edges_retired++;
		end
		if (!arst_n) begin
			push <= 1'b0;
			pop <= 1'b0;
		end else begin
			if (edge_stamps.size() != 0 &&
				!(edge_stamps[0].after_drain && symbols_in_flight.size() != 0) &&
				$urandom_range(99) >= send_idle) begin
				push <= 1'b1;
				edge_time <= edge_stamps[0].stamp;
			end else begin
				push <= 1'b0;
				edge_time <= tick_t'($urandom);
			end
			pop <= ($urandom_range(99) >= recv_stall);
		end
	end

	// Sample both handshakes at the rising edge.
	always @(posedge clk) begin : watch_ports
		pwsr_pkg::result_t want;
		if (arst_n) begin
			if (push && !full) begin
				edges_accepted++;
				decode_edge(edge_time);
			end
			if (pop && !empty) begin
				if (symbols_in_flight.size() == 0) begin
					report_mismatch($sformatf(
						"result item with none pending: burst %0d gap %0d",
						burst_length, gap_length));
				end else begin
					want = symbols_in_flight.pop_front();
					compare_field("symbol_valid", tick_t'(symbol_valid),
						tick_t'(want.symbol_valid));
					compare_field("symbol_value", tick_t'(symbol_value),
						tick_t'(want.symbol_value));
					compare_field("burst_length", burst_length, want.burst_length);
					compare_field("gap_length", gap_length, want.gap_length);
					compare_field("byte_ready", tick_t'(byte_ready),
						tick_t'(want.byte_ready));
					compare_field("byte_value", tick_t'(byte_value),
						tick_t'(want.byte_value));
					results_checked++;
					if (want.symbol_valid) begin
						symbols_matched++;
					end else begin
						pairs_unmatched++;
					end
					if (want.byte_ready) begin
						bytes_built++;
					end
				end
			end
		end
	end

	// Stimulus, reset and end of run.
	initial begin
		// The opening edge sits just below the wrap point, so the first burst wraps the timer.
		gen_stamp = 16'hFFF0;
		edge_stamps.push_back('{gen_stamp, 1'b0});
		queue_pair(16'd87, 16'd141, 1'b0);
		queue_pair(16'd486, 16'd276, 1'b0);
		// Zero lengths cannot match; the nibble pairing must stay put.
		queue_pair(16'd0, 16'd0, 1'b0);
		queue_pair(16'd174, 16'd554, 1'b0);
		// An unmatched pair between the nibbles keeps the held high nibble.
		queue_pair(16'hFFFF, 16'hFFFF, 1'b0);
		queue_pair(16'd278, 16'd484, 1'b0);
		// Lengths at and just past the edges of table ranges; some fall in the holes between them.
		queue_pair(16'd175, 16'd141, 1'b0);
		queue_pair(16'd87, 16'd208, 1'b0);
		queue_pair(16'd382, 16'd345, 1'b0);
		queue_pair(16'd399, 16'd207, 1'b0);
		queue_pair(16'd86, 16'd555, 1'b0);
		// The random part starts only after every directed result is out, and pauses once
		// more midway.
		for (int n = 0; n < RANDOM_PAIRS; n++) begin
			queue_random_pair(n == 0 || n == RANDOM_PAIRS / 2);
		end

		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (edge_stamps.size() != 0) @(posedge clk);
		while (symbols_in_flight.size() != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("Run covered %0d edge items and %0d results: %0d matched symbols, %0d %s",
			edges_accepted, results_checked, symbols_matched, pairs_unmatched,
			"unmatched pairs.");
		$display("It assembled %0d bytes and found %0d mismatches.", bytes_built, mismatches);
		if (mismatches == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

	// Guard against a hang.
	initial begin
		#RUN_LIMIT_NS;
		$display("Timeout: %0d of %0d results still pending.", symbols_in_flight.size(),
			results_checked + symbols_in_flight.size());
		$display("Verification failed");
		$finish;
	end

endmodule
